### hw/rtl/rvx_pkg.sv
`default_nettype none
package rvx_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int MODE_WIDTH  = 5;
   localparam int SHAMT_WIDTH = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

   localparam logic [DATA_WIDTH-1:0] UPPER_MASK = 32'hFFFFF000;
   localparam logic [DATA_WIDTH-1:0] ALL_ONES   = 32'hFFFFFFFF;
   localparam logic [DATA_WIDTH-1:0] LINK_STEP  = 32'd4;

   typedef enum logic [MODE_WIDTH-1:0] {
      OP_ADDI  = 5'd0,  OP_ANDI  = 5'd1,  OP_ORI  = 5'd2,  OP_XORI = 5'd3,
      OP_SLTI  = 5'd4,  OP_SLTIU = 5'd5,  OP_SLLI = 5'd6,  OP_SRLI = 5'd7,
      OP_SRAI  = 5'd8,  OP_LUI   = 5'd9,  OP_AUIPC = 5'd10, OP_ADD = 5'd11,
      OP_SUB   = 5'd12, OP_SLT   = 5'd13, OP_SLTU = 5'd14, OP_AND  = 5'd15,
      OP_OR    = 5'd16, OP_XOR   = 5'd17, OP_MUL  = 5'd18, OP_DIV  = 5'd19,
      OP_SLL   = 5'd20, OP_SRL   = 5'd21, OP_SRA  = 5'd22, OP_JAL  = 5'd23,
      OP_JALR  = 5'd24, OP_BEQ   = 5'd25, OP_BNE  = 5'd26, OP_BLT  = 5'd27,
      OP_BLTU  = 5'd28, OP_BGE   = 5'd29, OP_BGEU = 5'd30
   } op_type;

   typedef struct packed {
      logic                   is_div;
      logic [MODE_WIDTH-1:0]  mode;
      logic [DATA_WIDTH-1:0]  operand_a;
      logic [DATA_WIDTH-1:0]  operand_b;
      logic [DATA_WIDTH-1:0]  immediate;
      logic [SHAMT_WIDTH-1:0] shift_amount;
      logic [DATA_WIDTH-1:0]  instr_address;
   } item_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] result;
      logic                  branch_taken;
      logic [DATA_WIDTH-1:0] target_address;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage
`default_nettype wire

### hw/rtl/rvx_if.sv
`default_nettype none
interface rvx_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [rvx_pkg::MODE_WIDTH-1:0]  mode;
   logic signed [rvx_pkg::DATA_WIDTH-1:0]  operand_a;
   logic signed [rvx_pkg::DATA_WIDTH-1:0]  operand_b;
   logic signed [rvx_pkg::DATA_WIDTH-1:0]  immediate;
   logic        [rvx_pkg::SHAMT_WIDTH-1:0] shift_amount;
   logic        [rvx_pkg::DATA_WIDTH-1:0]  instr_address;
   modport source (output valid, mode, operand_a, operand_b, immediate, shift_amount,
                   instr_address, input ready);
   modport sink (input valid, mode, operand_a, operand_b, immediate, shift_amount,
                 instr_address, output ready);
endinterface

interface rvx_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rvx_pkg::DATA_WIDTH-1:0]   result;
   logic                             branch_taken;
   logic [rvx_pkg::DATA_WIDTH-1:0]   target_address;
   modport source (output valid, result, branch_taken, target_address, input ready);
   modport sink (input valid, result, branch_taken, target_address, output ready);
endinterface
`default_nettype wire

### hw/rtl/rvx_front.sv
`default_nettype none
module rvx_front (
   input  wire logic              clock,
   input  wire logic              reset,
   rvx_req_if.sink                req_chan,
   output rvx_pkg::item_type      push_item,
   output logic                   push_valid,
   input  wire logic              push_ready
);
   logic              valid_ff, valid_in;
   rvx_pkg::item_type item_ff, item_in;
   logic              load;

   assign req_chan.ready = !valid_ff || push_ready;
   assign load = req_chan.valid && req_chan.ready;

   always_comb begin
      item_in               = item_ff;
      valid_in              = valid_ff;
      if (push_ready) valid_in = 1'b0;
      if (load) begin
         valid_in               = 1'b1;
         item_in.is_div         = (req_chan.mode == rvx_pkg::OP_DIV);
         item_in.mode           = req_chan.mode;
         item_in.operand_a      = req_chan.operand_a;
         item_in.operand_b      = req_chan.operand_b;
         item_in.immediate      = req_chan.immediate;
         item_in.shift_amount   = req_chan.shift_amount;
         item_in.instr_address  = req_chan.instr_address;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      item_ff <= item_in;
   end

   assign push_item  = item_ff;
   assign push_valid = valid_ff;
endmodule
`default_nettype wire

### hw/rtl/rvx_queue.sv
`default_nettype none
module rvx_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rvx_pkg::item_type in_item,
   input  wire logic              in_valid,
   output logic                   in_ready,
   output rvx_pkg::item_type      out_item,
   output logic                   out_valid,
   input  wire logic              out_pop
);
   rvx_pkg::item_type                  mem_ff [rvx_pkg::QUEUE_DEPTH];
   logic [rvx_pkg::QPTR_WIDTH-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [rvx_pkg::QPTR_WIDTH:0]       count_ff, count_in;
   logic                               push, pop;

   assign in_ready  = (count_ff != rvx_pkg::QUEUE_DEPTH[rvx_pkg::QPTR_WIDTH:0]);
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;
   assign out_item  = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + {{rvx_pkg::QPTR_WIDTH{1'b0}}, push}
                          - {{rvx_pkg::QPTR_WIDTH{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) mem_ff[wr_ff] <= in_item;
   end
endmodule
`default_nettype wire

### hw/rtl/rvx_divider.sv
`default_nettype none
module rvx_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rvx_pkg::DATA_WIDTH-1:0] dividend,
   input  wire logic [rvx_pkg::DATA_WIDTH-1:0] divisor,
   input  wire logic                          ack,
   output rvx_pkg::div_status_type            status,
   output logic [rvx_pkg::DATA_WIDTH-1:0]     quotient
);
   localparam int W = rvx_pkg::DATA_WIDTH;

   logic                  busy_ff, done_ff;
   logic [$clog2(W)-1:0]  count_ff;
   logic [W-1:0]          rem_ff, quo_ff, den_ff;
   logic                  neg_ff, zero_ff;
   logic [W:0]            rem_sh, diff;

   assign rem_sh = {rem_ff, quo_ff[W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && count_ff == $clog2(W)'(W-1)) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end else if (ack) begin
         done_ff <= 1'b0;
      end
      if (start) begin
         count_ff <= '0;
         rem_ff   <= '0;
         quo_ff   <= dividend[W-1] ? W'(0) - dividend : dividend;
         den_ff   <= divisor[W-1] ? W'(0) - divisor : divisor;
         neg_ff   <= dividend[W-1] ^ divisor[W-1];
         zero_ff  <= (divisor == '0);
      end else if (busy_ff) begin
         count_ff <= count_ff + 1'b1;
         rem_ff   <= diff[W] ? rem_sh[W-1:0] : diff[W-1:0];
         quo_ff   <= {quo_ff[W-2:0], !diff[W]};
      end
   end

   assign status   = '{busy: busy_ff, done: done_ff};
   assign quotient = zero_ff ? rvx_pkg::ALL_ONES : (neg_ff ? W'(0) - quo_ff : quo_ff);
endmodule
`default_nettype wire

### hw/rtl/rvx_back.sv
`default_nettype none
module rvx_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rvx_pkg::item_type head,
   input  wire logic              head_valid,
   output logic                   pop,
   rvx_rsp_if.source              rsp_chan
);
   localparam int W = rvx_pkg::DATA_WIDTH;

   logic                    out_valid_ff, out_valid_in;
   rvx_pkg::rsp_type        out_ff, out_in, alu_out;
   logic                    load_ok, alu_fire, div_start, div_fire;
   rvx_pkg::div_status_type div_status;
   logic [W-1:0]            div_q;
   logic [W-1:0]            a, b, imm, pc, btgt;
   logic [4:0]              bsh;
   logic                    lts, ltu;

   rvx_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (head.operand_a),
      .divisor  (head.operand_b),
      .ack      (div_fire),
      .status   (div_status),
      .quotient (div_q)
   );

   assign load_ok   = !out_valid_ff || rsp_chan.ready;
   assign alu_fire  = head_valid && !head.is_div && load_ok;
   assign div_start = head_valid && head.is_div && !div_status.busy && !div_status.done;
   assign div_fire  = div_status.done && load_ok;
   assign pop       = alu_fire || div_fire;

   always_comb begin
      a    = head.operand_a;
      b    = head.operand_b;
      imm  = head.immediate;
      pc   = head.instr_address;
      bsh  = b[4:0];
      btgt = pc + imm;
      lts  = $signed(a) < $signed(b);
      ltu  = a < b;
      alu_out = '0;
      case (head.mode)
         rvx_pkg::OP_ADDI:  alu_out.result = a + imm;
         rvx_pkg::OP_ANDI:  alu_out.result = a & imm;
         rvx_pkg::OP_ORI:   alu_out.result = a | imm;
         rvx_pkg::OP_XORI:  alu_out.result = a ^ imm;
         rvx_pkg::OP_SLTI:  alu_out.result = W'($signed(a) < $signed(imm));
         rvx_pkg::OP_SLTIU: alu_out.result = W'(a < imm);
         rvx_pkg::OP_SLLI:  alu_out.result = a << head.shift_amount;
         rvx_pkg::OP_SRLI:  alu_out.result = a >> head.shift_amount;
         rvx_pkg::OP_SRAI:  alu_out.result = W'($signed(a) >>> head.shift_amount);
         rvx_pkg::OP_LUI:   alu_out.result = imm & rvx_pkg::UPPER_MASK;
         rvx_pkg::OP_AUIPC: alu_out.result = (imm & rvx_pkg::UPPER_MASK) + pc;
         rvx_pkg::OP_ADD:   alu_out.result = a + b;
         rvx_pkg::OP_SUB:   alu_out.result = a - b;
         rvx_pkg::OP_SLT:   alu_out.result = W'(lts);
         rvx_pkg::OP_SLTU:  alu_out.result = W'(ltu);
         rvx_pkg::OP_AND:   alu_out.result = a & b;
         rvx_pkg::OP_OR:    alu_out.result = a | b;
         rvx_pkg::OP_XOR:   alu_out.result = a ^ b;
         rvx_pkg::OP_MUL:   alu_out.result = a * b;
         rvx_pkg::OP_SLL:   alu_out.result = a << bsh;
         rvx_pkg::OP_SRL:   alu_out.result = a >> bsh;
         rvx_pkg::OP_SRA:   alu_out.result = W'($signed(a) >>> bsh);
         rvx_pkg::OP_JAL: begin
            alu_out.result         = pc + rvx_pkg::LINK_STEP;
            alu_out.branch_taken   = 1'b1;
            alu_out.target_address = btgt;
         end
         rvx_pkg::OP_JALR: begin
            alu_out.result         = pc + rvx_pkg::LINK_STEP;
            alu_out.branch_taken   = 1'b1;
            alu_out.target_address = (a + imm) & ~W'(1);
         end
         rvx_pkg::OP_BEQ: begin
            alu_out.branch_taken = (a == b);  alu_out.target_address = btgt;
         end
         rvx_pkg::OP_BNE: begin
            alu_out.branch_taken = (a != b);  alu_out.target_address = btgt;
         end
         rvx_pkg::OP_BLT: begin
            alu_out.branch_taken = lts;  alu_out.target_address = btgt;
         end
         rvx_pkg::OP_BLTU: begin
            alu_out.branch_taken = ltu;  alu_out.target_address = btgt;
         end
         rvx_pkg::OP_BGE: begin
            alu_out.branch_taken = !lts;  alu_out.target_address = btgt;
         end
         rvx_pkg::OP_BGEU: begin
            alu_out.branch_taken = !ltu;  alu_out.target_address = btgt;
         end
         default: alu_out = '0;
      endcase
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (rsp_chan.ready) out_valid_in = 1'b0;
      if (alu_fire) begin
         out_in       = alu_out;
         out_valid_in = 1'b1;
      end else if (div_fire) begin
         out_in       = '0;
         out_in.result = div_q;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else out_valid_ff <= out_valid_in;
      out_ff <= out_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.result         = out_ff.result;
   assign rsp_chan.branch_taken   = out_ff.branch_taken;
   assign rsp_chan.target_address = out_ff.target_address;
endmodule
`default_nettype wire

### hw/rtl/rv32im_execute_alu.sv
// RV32IM execute ALU. Items enter on req_chan with a valid/ready handshake and
// leave, one result per item and in order, on rsp_chan. A front register takes
// each item and files it into a four-entry queue; the back end executes the
// queue head and holds its result in an output register. All operations but
// div sustain one item per cycle while rsp_chan is ready. A div holds the back
// end in its shift-subtract divider, which retires one quotient bit per cycle;
// the front keeps accepting until the queue fills.
`default_nettype none
module rv32im_execute_alu (
   input  wire logic clock,
   input  wire logic reset,
   rvx_req_if.sink   req_chan,
   rvx_rsp_if.source rsp_chan
);
   rvx_pkg::item_type push_item, head_item;
   logic              push_valid, push_ready, head_valid, head_pop;

   rvx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   rvx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_item   (push_item),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .out_item  (head_item),
      .out_valid (head_valid),
      .out_pop   (head_pop)
   );

   rvx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_item),
      .head_valid (head_valid),
      .pop        (head_pop),
      .rsp_chan   (rsp_chan)
   );
endmodule
`default_nettype wire

### hw/rtl/rvx_checker.sv
`default_nettype none
module rvx_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_result,
   input wire logic [31:0] rsp_target
);
   logic [3:0] pending_ff;
   logic       in_acc, out_acc;

   assign in_acc  = req_valid && req_ready;
   assign out_acc = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) pending_ff <= '0;
      else pending_ff <= pending_ff + {3'b0, in_acc} - {3'b0, out_acc};
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp valid dropped");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_result) && $stable(rsp_target))
      else $error("rsp payload changed while stalled");
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0) else $error("rsp without item");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("rsp valid after reset");
endmodule

bind rv32im_execute_alu rvx_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_result (rsp_chan.result),
   .rsp_target (rsp_chan.target_address)
);
`default_nettype wire

### tb/tb_rv32im_execute_alu_if.sv
`timescale 1ns / 100ps
// Scoreboard for the execute ALU bench.
class alu_scoreboard;
   typedef struct packed {
      logic [31:0] result;
      logic        branch_taken;
      logic [31:0] target_address;
   } alu_out_type;

   alu_out_type pending[$];
   int unsigned mismatches;
   int unsigned checked;

   function new();
      mismatches = 0;
      checked = 0;
   endfunction

   static function logic [31:0] sra32(logic [31:0] v, logic [4:0] sh);
      return $unsigned($signed(v) >>> sh);
   endfunction

   static function logic [31:0] div32(logic [31:0] x, logic [31:0] y);
      logic [31:0] mx, my, q;
      if (y == 32'h0) return 32'hFFFF_FFFF;
      if (x == 32'h8000_0000 && y == 32'hFFFF_FFFF) return 32'h8000_0000;
      mx = x[31] ? -x : x;
      my = y[31] ? -y : y;
      q = mx / my;
      return (x[31] ^ y[31]) ? -q : q;
   endfunction

   function void note_issue(logic [4:0] mode, logic [31:0] a, logic [31:0] b,
                            logic [31:0] imm, logic [4:0] sh, logic [31:0] pc);
      alu_out_type e;
      logic [31:0] btgt;
      logic slt_ab;
      btgt = pc + imm;
      slt_ab = $signed(a) < $signed(b);
      e = '0;
      case (mode)
         rvx_pkg::OP_ADDI:  e.result = a + imm;
         rvx_pkg::OP_ANDI:  e.result = a & imm;
         rvx_pkg::OP_ORI:   e.result = a | imm;
         rvx_pkg::OP_XORI:  e.result = a ^ imm;
         rvx_pkg::OP_SLTI:  e.result = {31'b0, $signed(a) < $signed(imm)};
         rvx_pkg::OP_SLTIU: e.result = {31'b0, a < imm};
         rvx_pkg::OP_SLLI:  e.result = a << sh;
         rvx_pkg::OP_SRLI:  e.result = a >> sh;
         rvx_pkg::OP_SRAI:  e.result = sra32(a, sh);
         rvx_pkg::OP_LUI:   e.result = imm & rvx_pkg::UPPER_MASK;
         rvx_pkg::OP_AUIPC: e.result = (imm & rvx_pkg::UPPER_MASK) + pc;
         rvx_pkg::OP_ADD:   e.result = a + b;
         rvx_pkg::OP_SUB:   e.result = a - b;
         rvx_pkg::OP_SLT:   e.result = {31'b0, slt_ab};
         rvx_pkg::OP_SLTU:  e.result = {31'b0, a < b};
         rvx_pkg::OP_AND:   e.result = a & b;
         rvx_pkg::OP_OR:    e.result = a | b;
         rvx_pkg::OP_XOR:   e.result = a ^ b;
         rvx_pkg::OP_MUL:   e.result = a * b;
         rvx_pkg::OP_DIV:   e.result = div32(a, b);
         rvx_pkg::OP_SLL:   e.result = a << b[4:0];
         rvx_pkg::OP_SRL:   e.result = a >> b[4:0];
         rvx_pkg::OP_SRA:   e.result = sra32(a, b[4:0]);
         rvx_pkg::OP_JAL: begin
            e.result = pc + rvx_pkg::LINK_STEP;
            e.branch_taken = 1'b1;
            e.target_address = btgt;
         end
         rvx_pkg::OP_JALR: begin
            e.result = pc + rvx_pkg::LINK_STEP;
            e.branch_taken = 1'b1;
            e.target_address = (a + imm) & ~32'h1;
         end
         rvx_pkg::OP_BEQ:  begin e.branch_taken = a == b; e.target_address = btgt; end
         rvx_pkg::OP_BNE:  begin e.branch_taken = a != b; e.target_address = btgt; end
         rvx_pkg::OP_BLT:  begin e.branch_taken = slt_ab; e.target_address = btgt; end
         rvx_pkg::OP_BLTU: begin e.branch_taken = a < b; e.target_address = btgt; end
         rvx_pkg::OP_BGE:  begin e.branch_taken = !slt_ab; e.target_address = btgt; end
         rvx_pkg::OP_BGEU: begin e.branch_taken = !(a < b); e.target_address = btgt; end
         default: e = '0;
      endcase
      pending.push_back(e);
   endfunction

   function void check_result(logic [31:0] res, logic taken, logic [31:0] tgt);
      alu_out_type e;
      checked++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result %h %b %h", res, taken, tgt);
         return;
      end
      e = pending.pop_front();
      if (res !== e.result || taken !== e.branch_taken || tgt !== e.target_address) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: exp %h %b %h got %h %b %h", e.result, e.branch_taken,
                     e.target_address, res, taken, tgt);
      end
   endfunction
endclass

### tb/tb_rv32im_execute_alu.sv
`timescale 1ns / 100ps
module tb_rv32im_execute_alu;

   logic clock;
   logic reset;
   rvx_req_if req_chan();
   rvx_rsp_if rsp_chan();
   alu_scoreboard board;
   bit calm;
   int unsigned issued;

   rv32im_execute_alu uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(0, 40);
         5: return -$urandom_range(1, 40);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_op(logic [4:0] mode, logic [31:0] a, logic [31:0] b,
                          logic [31:0] imm, logic [4:0] sh, logic [31:0] pc);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 15);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= mode;
      req_chan.operand_a <= a;
      req_chan.operand_b <= b;
      req_chan.immediate <= imm;
      req_chan.shift_amount <= sh;
      req_chan.instr_address <= pc;
      do @(posedge clock); while (!req_chan.ready);
      board.note_issue(mode, a, b, imm, sh, pc);
      issued++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_result(rsp_chan.result, rsp_chan.branch_taken, rsp_chan.target_address);
   end

   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 15);
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   initial begin
      int wait_cycles;
      logic [4:0] m;
      board = new();
      calm = 1'b0;
      issued = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.mode = '0;
      req_chan.operand_a = '0;
      req_chan.operand_b = '0;
      req_chan.immediate = '0;
      req_chan.shift_amount = '0;
      req_chan.instr_address = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int k = rvx_pkg::OP_ADDI; k <= rvx_pkg::OP_BGEU; k++)
         send_op(k[4:0], 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 5'd31, 32'hFFFF_FFFC);
      send_op(rvx_pkg::OP_DIV, 32'd7, 32'd0, 32'd0, 5'd0, 32'd0);
      send_op(rvx_pkg::OP_DIV, -32'sd7, 32'd2, 32'd0, 5'd0, 32'd0);
      send_op(rvx_pkg::OP_SRA, 32'hF000_0000, 32'hFFFF_FFE4, 32'd0, 5'd0, 32'd0);
      send_op(rvx_pkg::OP_BEQ, 32'h1234, 32'h1234, 32'hFFFF_FFF0, 5'd0, 32'h100);
      send_op(rvx_pkg::OP_JALR, 32'h1001, 32'd2, 32'd0, 5'd0, 32'h4);
      send_op(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFF);

      for (int n = 0; n < 920; n++) begin
         if (n == 820) calm = 1'b1;
         m = ($urandom_range(0, 30) == 0) ? 5'd31 : 5'($urandom_range(0, 30));
         send_op(m, pick_word(), pick_word(), pick_word(), 5'($urandom), $urandom);
      end
      req_chan.valid <= 1'b0;

      wait_cycles = 0;
      while (board.pending.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (40) @(posedge clock);
      $display("sent %0d items over all %0d codes; %0d results checked, %0d mismatches",
               issued, 32, board.checked, board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

### sim.f
hw/rtl/rvx_pkg.sv
hw/rtl/rvx_if.sv
hw/rtl/rvx_front.sv
hw/rtl/rvx_queue.sv
hw/rtl/rvx_divider.sv
hw/rtl/rvx_back.sv
hw/rtl/rv32im_execute_alu.sv
hw/rtl/rvx_checker.sv
tb/tb_rv32im_execute_alu_if.sv
tb/tb_rv32im_execute_alu.sv
